>>> hdl/pbv_pkg.sv
package pbv_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned MaxWords = 1024;  // 65536-bit cap over 64-bit words

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        err;
    logic [63:0] value;
    logic [15:0] start;
    logic [6:0]  width;
    logic [16:0] bit_length;
  } cmd_t;

  function automatic logic [63:0] low_mask(input logic [6:0] w);
    logic [63:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

>>> hdl/pbv_front.sv
module pbv_front #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [63:0]   value_i,
  input  logic [6:0]    width_i,
  input  logic [15:0]   position_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output pbv_pkg::cmd_t cmd_o
);
  import pbv_pkg::*;

  localparam int unsigned UsedWords = (STORE_WORDS > MaxWords) ? MaxWords : STORE_WORDS;
  localparam logic [17:0] CapBits = 18'(UsedWords * WordBits);

  logic [16:0] length_q, length_d;
  logic        width_ok;
  logic [17:0] app_end;
  logic [16:0] rd_end;
  cmd_t        cmd;

  always_comb begin
    width_ok = (width_i != 7'd0) && (width_i <= 7'd64);
    app_end  = {1'b0, length_q} + 18'(width_i);
    rd_end   = {1'b0, position_i} + 17'(width_i);
    length_d = length_q;

    cmd.kind  = KindNone;
    cmd.err   = 1'b0;
    cmd.value = value_i & low_mask(width_i);
    cmd.start = position_i;
    cmd.width = width_i;

    unique case (opcode_i)
      OpAppend: begin
        if (!width_ok || (app_end > CapBits)) begin
          cmd.err = 1'b1;
        end else begin
          cmd.kind  = KindAppend;
          cmd.start = length_q[15:0];
          length_d  = app_end[16:0];
        end
      end
      OpRead: begin
        if (!width_ok || (rd_end > length_q)) begin
          cmd.err = 1'b1;
        end else begin
          cmd.kind = KindRead;
        end
      end
      OpClear: length_d = '0;
      default: ;
    endcase

    cmd.bit_length = length_d;
  end

  assign ready_o     = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
    end else if (valid_i && cmd_ready_i) begin
      length_q <= length_d;
    end
  end

endmodule

>>> hdl/pbv_fifo.sv
module pbv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pbv_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pbv_pkg::cmd_t out_cmd_o
);
  import pbv_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_cmd_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> hdl/pbv_back.sv
module pbv_back #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  pbv_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [63:0]   read_data_o,
  output logic [16:0]   bit_length_o,
  output logic          error_o
);
  import pbv_pkg::*;

  localparam int unsigned UsedWords = (STORE_WORDS > MaxWords) ? MaxWords : STORE_WORDS;
  localparam int unsigned AddrW     = (UsedWords > 1) ? $clog2(UsedWords) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StApp2 = 2'd1;
  localparam logic [1:0] StRd1  = 2'd2;
  localparam logic [1:0] StRd2  = 2'd3;

  logic [63:0] mem_q [UsedWords];
  logic [63:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata;

  logic [1:0]       state_q, state_d;
  logic [63:0]      tail_q, tail_d;
  logic [63:0]      hi_q, hi_d;
  logic [5:0]       off_q, off_d;
  logic [6:0]       width_q, width_d;
  logic [AddrW-1:0] addr2_q, addr2_d;
  logic [16:0]      len_q, len_d;

  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  logic [16:0] out_len_q, out_len_d;
  logic        out_err_q, out_err_d;
  logic        out_load;

  logic        slot_free, pop;
  logic [5:0]  cmd_off;
  logic [9:0]  cmd_wi, cmd_wi_next;
  logic        cmd_span, rd_span;
  logic [63:0] low_word, lo;

  assign slot_free   = !out_valid_q || ready_i;
  assign cmd_ready_o = (state_q == StIdle) && slot_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    cmd_off     = cmd_i.start[5:0];
    cmd_wi      = cmd_i.start[15:6];
    cmd_wi_next = cmd_wi + 10'd1;
    cmd_span    = (7'(cmd_off) + cmd_i.width) > 7'd64;
    rd_span     = (7'(off_q) + width_q) > 7'd64;
    low_word    = (cmd_off == 6'd0) ? cmd_i.value : (tail_q | (cmd_i.value << cmd_off));
    lo          = rdata_q >> off_q;

    state_d = state_q;
    tail_d  = tail_q;
    hi_d    = hi_q;
    off_d   = off_q;
    width_d = width_q;
    addr2_d = addr2_q;
    len_d   = len_q;

    mem_we    = 1'b0;
    mem_waddr = cmd_wi[AddrW-1:0];
    mem_wdata = low_word;
    mem_re    = 1'b0;
    mem_raddr = cmd_wi[AddrW-1:0];

    out_load   = 1'b0;
    out_data_d = '0;
    out_len_d  = len_q;
    out_err_d  = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (pop) begin
          unique case (cmd_i.kind)
            KindAppend: begin
              mem_we    = 1'b1;
              out_load  = 1'b1;
              out_len_d = cmd_i.bit_length;
              addr2_d   = cmd_wi_next[AddrW-1:0];
              if (cmd_span) begin
                hi_d    = cmd_i.value >> (7'd64 - 7'(cmd_off));
                state_d = StApp2;
              end else begin
                tail_d = low_word;
              end
            end
            KindRead: begin
              mem_re  = 1'b1;
              off_d   = cmd_off;
              width_d = cmd_i.width;
              addr2_d = cmd_wi_next[AddrW-1:0];
              len_d   = cmd_i.bit_length;
              state_d = StRd1;
            end
            default: begin
              out_load  = 1'b1;
              out_len_d = cmd_i.bit_length;
              out_err_d = cmd_i.err;
            end
          endcase
        end
      end
      StApp2: begin
        // Upper part of a field that crossed into the next word
        mem_we    = 1'b1;
        mem_waddr = addr2_q;
        mem_wdata = hi_q;
        tail_d    = hi_q;
        state_d   = StIdle;
      end
      StRd1: begin
        if (rd_span) begin
          mem_re    = 1'b1;
          mem_raddr = addr2_q;
          hi_d      = lo;
          state_d   = StRd2;
        end else begin
          out_load   = 1'b1;
          out_data_d = lo & low_mask(width_q);
          state_d    = StIdle;
        end
      end
      StRd2: begin
        out_load   = 1'b1;
        out_data_d = (hi_q | (rdata_q << (7'd64 - 7'(off_q)))) & low_mask(width_q);
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q  <= tail_d;
    hi_q    <= hi_d;
    off_q   <= off_d;
    width_q <= width_d;
    addr2_q <= addr2_d;
    len_q   <= len_d;
    if (out_load) begin
      out_data_q <= out_data_d;
      out_len_q  <= out_len_d;
      out_err_q  <= out_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign valid_o      = out_valid_q;
  assign read_data_o  = out_data_q;
  assign bit_length_o = out_len_q;
  assign error_o      = out_err_q;

endmodule

>>> hdl/packed_bit_vector_store.sv
// Each item goes through the command queue to the back end's output register; a read
// first loads the memory read register, and again for the next word if it crosses one.
// Throughput: one item a cycle for append, clear and rejected items while ready_i
// is high; the back end takes no new item while it finishes a crossing append or a read.
// Reset clears the length, the command queue and the output register; the word
// memory is not cleared and needs no pass after reset.
module packed_bit_vector_store #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] value_i,
  input  logic [6:0]  width_i,
  input  logic [15:0] position_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] read_data_o,
  output logic [16:0] bit_length_o,
  output logic        error_o
);
  import pbv_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  pbv_front #(
    .STORE_WORDS(STORE_WORDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .ready_o    (ready_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .width_i    (width_i),
    .position_i (position_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  pbv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (front_valid),
    .in_ready_o (front_ready),
    .in_cmd_i   (front_cmd),
    .out_valid_o(back_valid),
    .out_ready_i(back_ready),
    .out_cmd_o  (back_cmd)
  );

  pbv_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .read_data_o (read_data_o),
    .bit_length_o(bit_length_o),
    .error_o     (error_o)
  );

endmodule
